// ----- rtl/generator_reply_event_decoder_core_macros.svh -----
// Assertion macros shared by the decoder modules.
// GRED_ASSERT checks outside reset; GRED_ASSERT_ALWAYS also checks during reset.
`ifndef GENERATOR_REPLY_EVENT_DECODER_CORE_MACROS_SVH
`define GENERATOR_REPLY_EVENT_DECODER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GRED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GRED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRED_ASSERT(lbl, prop, msg)
`define GRED_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/gred_pkg.sv -----
package gred_pkg;

  localparam int POS_W         = 6;
  localparam int DEFAULT_MAX_FRAME_LEN = 32;
  localparam int CODE_W        = 4;
  localparam int VALUE_W       = 10;
  localparam int NUM_EVENTS    = 13;
  localparam int NUM_SLOTS     = 15;
  localparam int SLOT_W        = 4;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  // event codes
  localparam logic [CODE_W-1:0] EV_MODE      = 4'd0;
  localparam logic [CODE_W-1:0] EV_STOPPED   = 4'd1;
  localparam logic [CODE_W-1:0] EV_KVP       = 4'd2;
  localparam logic [CODE_W-1:0] EV_MA        = 4'd3;
  localparam logic [CODE_W-1:0] EV_ELAPSED   = 4'd4;
  localparam logic [CODE_W-1:0] EV_SHOOT     = 4'd5;
  localparam logic [CODE_W-1:0] EV_STARTED   = 4'd6;
  localparam logic [CODE_W-1:0] EV_ERROR     = 4'd7;
  localparam logic [CODE_W-1:0] EV_WARM_DONE = 4'd8;
  localparam logic [CODE_W-1:0] EV_WARM_SHORT = 4'd9;
  localparam logic [CODE_W-1:0] EV_WARM_LONG = 4'd10;
  localparam logic [CODE_W-1:0] EV_LARGE_SPOT = 4'd11;
  localparam logic [CODE_W-1:0] EV_SMALL_SPOT = 4'd12;
  localparam logic [CODE_W-1:0] EV_NONE      = 4'd13;

  // slots of the run, in emission order
  localparam logic [SLOT_W-1:0] SL_MODE     = 4'd0;
  localparam logic [SLOT_W-1:0] SL_STOPPED  = 4'd1;
  localparam logic [SLOT_W-1:0] SL_KVP      = 4'd2;
  localparam logic [SLOT_W-1:0] SL_MA       = 4'd3;
  localparam logic [SLOT_W-1:0] SL_ELAPSED  = 4'd4;
  localparam logic [SLOT_W-1:0] SL_SHOOT    = 4'd5;
  localparam logic [SLOT_W-1:0] SL_STARTED  = 4'd6;
  localparam logic [SLOT_W-1:0] SL_ERROR    = 4'd7;
  localparam logic [SLOT_W-1:0] SL_QX_KVP   = 4'd8;
  localparam logic [SLOT_W-1:0] SL_QX_MA    = 4'd9;
  localparam logic [SLOT_W-1:0] SL_QX_SHOOT = 4'd10;
  localparam logic [SLOT_W-1:0] SL_WARM     = 4'd11;
  localparam logic [SLOT_W-1:0] SL_LARGE    = 4'd12;
  localparam logic [SLOT_W-1:0] SL_SMALL    = 4'd13;
  localparam logic [SLOT_W-1:0] SL_NONE     = 4'd14;

  // pattern flags
  localparam int F_M   = 0;
  localparam int F_V   = 1;
  localparam int F_I   = 2;
  localparam int F_E   = 3;
  localparam int F_XO  = 4;
  localparam int F_QT  = 5;
  localparam int F_XT  = 6;
  localparam int F_XX  = 7;
  localparam int F_QX  = 8;
  localparam int F_QW  = 9;
  localparam int F_QFB = 10;
  localparam int F_QFF = 11;
  localparam int NUM_FLAGS = 12;

  localparam logic [VALUE_W-1:0] WARM_SHORT_VAL = 10'd100;
  localparam logic [VALUE_W-1:0] WARM_LONG_VAL  = 10'd101;

  typedef logic [7:0] char_t;
  typedef logic [VALUE_W-1:0] value_t;

  // one finished frame, handed from scanner to emitter
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [CODE_W-1:0]    warm_code;
    value_t               f2;
    value_t               f1;
    value_t               f0;
  } summary_t;

  function automatic logic [CODE_W-1:0] slot_code(input logic [SLOT_W-1:0] slot,
                                                  input logic [CODE_W-1:0] warm);
    logic [CODE_W-1:0] code;
    case (slot)
      SL_MODE:     code = EV_MODE;
      SL_STOPPED:  code = EV_STOPPED;
      SL_KVP:      code = EV_KVP;
      SL_MA:       code = EV_MA;
      SL_ELAPSED:  code = EV_ELAPSED;
      SL_SHOOT:    code = EV_SHOOT;
      SL_STARTED:  code = EV_STARTED;
      SL_ERROR:    code = EV_ERROR;
      SL_QX_KVP:   code = EV_KVP;
      SL_QX_MA:    code = EV_MA;
      SL_QX_SHOOT: code = EV_SHOOT;
      SL_WARM:     code = warm;
      SL_LARGE:    code = EV_LARGE_SPOT;
      SL_SMALL:    code = EV_SMALL_SPOT;
      default:     code = EV_NONE;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/gred_scan.sv -----
`include "generator_reply_event_decoder_core_macros.svh"
module gred_scan import gred_pkg::*; #(
  parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_char
  input  logic                  s_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [NUM_EVENTS-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output summary_t              q_wdata
);

  localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_FRAME_LEN);

  logic [NUM_EVENTS-1:0] event_enable;
  logic [POS_W-1:0]      char_position, char_position_next;
  char_t                 prev_char, prev2_char;
  logic [NUM_FLAGS-1:0]  flags, flags_next;
  value_t                field_val [3];
  value_t                field_val_next [3];
  logic [2:0]            field_vld, field_vld_next, field_ok;
  logic                  xfer, take, dig;
  logic [3:0]            digit;
  logic [13:0]           cand, cut, mask14;
  logic [CODE_W-1:0]     warm_code;

  assign s_tready  = !q_full;
  assign cfg_ready = 1'b1;
  assign xfer      = s_tvalid && s_tready;
  assign take      = xfer && (char_position < MaxPos);
  assign dig       = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
  assign digit     = s_tdata[3:0];

  always_comb begin
    logic [13:0] prod;
    logic [POS_W-1:0] start;
    flags_next = flags;
    if (take) begin
      if (s_tdata == "M") flags_next[F_M] = 1'b1;
      if (s_tdata == "V") flags_next[F_V] = 1'b1;
      if (s_tdata == "I") flags_next[F_I] = 1'b1;
      if (s_tdata == "E") flags_next[F_E] = 1'b1;
      if (prev_char == "!" && s_tdata == "O") flags_next[F_XO] = 1'b1;
      if (prev_char == "?" && s_tdata == "T") flags_next[F_QT] = 1'b1;
      if (prev_char == "!" && s_tdata == "T") flags_next[F_XT] = 1'b1;
      if (prev_char == "!" && s_tdata == "X") flags_next[F_XX] = 1'b1;
      if (prev_char == "?" && s_tdata == "X") flags_next[F_QX] = 1'b1;
      if (prev_char == "?" && s_tdata == "W") flags_next[F_QW] = 1'b1;
      if (prev2_char == "?" && prev_char == "F" && s_tdata == "B") flags_next[F_QFB] = 1'b1;
      if (prev2_char == "?" && prev_char == "F" && s_tdata == "F") flags_next[F_QFF] = 1'b1;
    end
    char_position_next = take ? char_position + POS_W'(1) : char_position;
    for (int k = 0; k < 3; k++) begin
      start = POS_W'(2 + 4 * k);
      field_val_next[k] = field_val[k];
      field_vld_next[k] = field_vld[k];
      prod = {field_val[k], 3'b000} + {3'b000, field_val[k], 1'b0} + {10'd0, digit};
      if (take && char_position == start) begin
        field_vld_next[k] = dig;
        field_val_next[k] = dig ? {6'd0, digit} : '0;
      end else if (take && char_position > start && char_position < start + POS_W'(3)) begin
        field_vld_next[k] = field_vld[k] && dig;
        if (dig) field_val_next[k] = prod[VALUE_W-1:0];
      end
      field_ok[k] = field_vld_next[k] && (char_position_next >= start + POS_W'(3));
    end
  end

  // candidate events in run order, then cut at the first run-ending pattern
  always_comb begin
    cand[SL_MODE]     = flags_next[F_M] && field_ok[0];
    cand[SL_STOPPED]  = flags_next[F_XO];
    cand[SL_KVP]      = flags_next[F_V] && field_ok[0];
    cand[SL_MA]       = flags_next[F_I] && field_ok[0];
    cand[SL_ELAPSED]  = flags_next[F_QT] && field_ok[0];
    cand[SL_SHOOT]    = flags_next[F_XT] && field_ok[0];
    cand[SL_STARTED]  = flags_next[F_XX];
    cand[SL_ERROR]    = flags_next[F_E];
    cand[SL_QX_KVP]   = flags_next[F_QX] && field_ok[0];
    cand[SL_QX_MA]    = flags_next[F_QX] && field_ok[1];
    cand[SL_QX_SHOOT] = flags_next[F_QX] && field_ok[2];
    cand[SL_WARM]     = flags_next[F_QW] && field_ok[0] &&
                        (field_val_next[0] == '0 || field_val_next[0] == WARM_SHORT_VAL ||
                         field_val_next[0] == WARM_LONG_VAL);
    cand[SL_LARGE]    = flags_next[F_QFB];
    cand[SL_SMALL]    = flags_next[F_QFF];

    if (field_val_next[0] == '0) warm_code = EV_WARM_DONE;
    else if (field_val_next[0] == WARM_SHORT_VAL) warm_code = EV_WARM_SHORT;
    else warm_code = EV_WARM_LONG;

    if (flags_next[F_XO]) cut = 14'h0003;
    else if (flags_next[F_XX]) cut = 14'h007F;
    else if (flags_next[F_QX]) cut = 14'h07FF;
    else if (flags_next[F_QFB]) cut = 14'h1FFF;
    else cut = 14'h3FFF;

    for (int s = 0; s < 14; s++) begin
      mask14[s] = cand[s] && cut[s] && event_enable[slot_code(SLOT_W'(s), warm_code)];
    end
  end

  assign q_push            = xfer && s_tlast;
  assign q_wdata.mask      = {mask14 == '0, mask14};
  assign q_wdata.warm_code = warm_code;
  assign q_wdata.f0        = field_val_next[0];
  assign q_wdata.f1        = field_val_next[1];
  assign q_wdata.f2        = field_val_next[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      event_enable  <= '0;
      char_position <= '0;
      prev_char     <= '0;
      prev2_char    <= '0;
      flags         <= '0;
      field_vld     <= '0;
      for (int k = 0; k < 3; k++) field_val[k] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) event_enable <= cfg_data;
      if (q_push) begin
        // frame done: clear for the next one
        char_position <= '0;
        prev_char     <= '0;
        prev2_char    <= '0;
        flags         <= '0;
        field_vld     <= '0;
        for (int k = 0; k < 3; k++) field_val[k] <= '0;
      end else begin
        if (take) begin
          prev_char  <= s_tdata;
          prev2_char <= prev_char;
        end
        char_position <= char_position_next;
        flags         <= flags_next;
        field_vld     <= field_vld_next;
        for (int k = 0; k < 3; k++) field_val[k] <= field_val_next[k];
      end
    end
  end

  `GRED_ASSERT(a_pos_saturates, char_position <= MaxPos, "frame position past limit")
  `GRED_ASSERT(a_push_clears, q_push |=> (char_position == '0 && flags == '0), "frame state not cleared")
  `GRED_ASSERT(a_push_mask, q_push |-> q_wdata.mask != '0, "empty run pushed")

endmodule

// ----- rtl/gred_fifo.sv -----
`include "generator_reply_event_decoder_core_macros.svh"
module gred_fifo import gred_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  summary_t wdata,
  input  logic     pop,
  output summary_t rdata,
  output logic     empty,
  output logic     full
);

  summary_t           mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QCNT_W'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `GRED_ASSERT(a_count_range, count <= QCNT_W'(QDEPTH), "queue count out of range")
  `GRED_ASSERT(a_push_fills, (do_push && !do_pop) |=> !empty, "pushed entry lost")

endmodule

// ----- rtl/gred_emit.sv -----
`include "generator_reply_event_decoder_core_macros.svh"
module gred_emit import gred_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  summary_t       q_rdata,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata,   // event_code[3:0], event_value[13:4], zero[15:14]
  output logic           m_tlast
);

  logic                 busy;
  logic [NUM_SLOTS-1:0] rem, low, rem_after;
  logic [CODE_W-1:0]    warm_code;
  value_t               f0, f1, f2;
  logic [SLOT_W-1:0]    slot;
  logic [CODE_W-1:0]    code;
  value_t               value;
  logic                 fire;
  logic [CODE_W-1:0]    out_code;
  value_t               out_value;

  assign q_pop     = !busy && !q_empty;
  assign fire      = busy && (!m_tvalid || m_tready);
  assign low       = rem & (~rem + NUM_SLOTS'(1));
  assign rem_after = rem & ~low;

  always_comb begin
    slot = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (low[s]) slot = SLOT_W'(s);
    end
    code = slot_code(slot, warm_code);
    case (slot)
      SL_MODE, SL_KVP, SL_MA, SL_ELAPSED, SL_SHOOT, SL_QX_KVP: value = f0;
      SL_QX_MA:    value = f1;
      SL_QX_SHOOT: value = f2;
      default:     value = '0;
    endcase
  end

  assign m_tdata = {2'b00, out_value, out_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rem      <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        rem  <= q_rdata.mask;
      end else if (fire) begin
        rem <= rem_after;
        if (rem_after == '0) busy <= 1'b0;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
        m_tlast  <= (rem_after == '0);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      warm_code <= q_rdata.warm_code;
      f0        <= q_rdata.f0;
      f1        <= q_rdata.f1;
      f2        <= q_rdata.f2;
    end
    if (fire) begin
      out_code  <= code;
      out_value <= value;
    end
  end

  `GRED_ASSERT(a_busy_has_work, busy |-> rem != '0, "emitter busy with nothing left")
  `GRED_ASSERT(a_run_ends_last, $fell(busy) |-> (m_tvalid && m_tlast), "run ended without last")
  `GRED_ASSERT(a_plain_no_value,
    (m_tvalid && (out_code == EV_STOPPED || out_code == EV_STARTED || out_code == EV_ERROR ||
     out_code == EV_NONE)) |-> out_value == '0, "value on an event without one")

endmodule

// ----- rtl/generator_reply_event_decoder_core.sv -----
// Reply-frame event decoder. Characters of a generator reply frame arrive on the
// s_ side, one per transfer, s_tlast on the last one; the decoder takes one per
// cycle. At the frame end the scanner pushes a frame summary (events that survive
// the enable mask and the run's early exits, plus the decoded fields) into a
// two-entry queue. The emitter drains the queue and sends one event per cycle on
// the m_ side while m_tready is high, with m_tlast on the final event of each
// frame; a frame with no event gives one "none" event. The emitter spends a
// load step on each frame's summary, with no new event out. s_tready drops only
// while both queue entries wait. cfg_data (event_enable, bit k enables code k) is
// written whenever cfg_valid is high and should change only while the block is idle.
module generator_reply_event_decoder_core import gred_pkg::*; #(
  parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_char[7:0]
  input  logic                  s_tlast,   // end_of_frame
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // event_code[3:0], event_value[13:4], zero[15:14]
  output logic                  m_tlast,   // last_event
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [NUM_EVENTS-1:0] cfg_data
);

  summary_t q_wdata, q_rdata;
  logic     q_push, q_pop, q_empty, q_full;

  gred_scan #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_scan (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .cfg_valid, .cfg_ready, .cfg_data,
    .q_full, .q_push, .q_wdata
  );

  gred_fifo u_fifo (
    .clk, .rst,
    .push(q_push), .wdata(q_wdata),
    .pop(q_pop), .rdata(q_rdata),
    .empty(q_empty), .full(q_full)
  );

  gred_emit u_emit (
    .clk, .rst,
    .q_rdata, .q_empty, .q_pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule

// ----- tb/sv/generator_reply_event_decoder_core_test.sv -----
module generator_reply_event_decoder_core_test;
  import gred_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN        = DEFAULT_MAX_FRAME_LEN;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 20;
  localparam int TIMEOUT_NS     = 5_000_000;

  typedef struct {
    logic [CODE_W-1:0] code;
    value_t            value;
    logic              is_last;
  } reply_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // rx_char[7:0]
  logic                  s_tlast = 1'b0; // end_of_frame
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;        // event_code[3:0], event_value[13:4], zero[15:14]
  logic                  m_tlast;        // last_event
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [NUM_EVENTS-1:0] cfg_data = '0;

  // decoder state as seen by the predictor
  logic [NUM_EVENTS-1:0] enable_mask = '0;
  int                    scan_pos = 0;
  char_t                 last_char = '0;
  char_t                 last2_char = '0;
  logic [NUM_FLAGS-1:0]  seen_flags = '0;
  value_t                field_val [3];
  bit                    field_digits_ok [3];

  reply_event_t          expected_events [$];
  int                    errors = 0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    hold_req = 0;
  int                    hold_ack = 0;
  int                    hold_left = 0;

  generator_reply_event_decoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_frame_state();
    scan_pos   = 0;
    last_char  = '0;
    last2_char = '0;
    seen_flags = '0;
    for (int k = 0; k < 3; k++) begin
      field_val[k]       = '0;
      field_digits_ok[k] = 1'b0;
    end
  endfunction

  function automatic bit field_complete(input int k);
    return field_digits_ok[k] && scan_pos >= 2 + 4 * k + 3;
  endfunction

  function automatic void queue_event(input logic [CODE_W-1:0] code, input value_t value);
    reply_event_t ev;
    ev.code    = code;
    ev.value   = value;
    ev.is_last = 1'b0;
    if (enable_mask[code]) expected_events.push_back(ev);
  endfunction

  function automatic void scan_char(input char_t c);
    bit dig;
    int start;
    dig = (c >= "0") && (c <= "9");
    if (c == "M") seen_flags[F_M] = 1'b1;
    if (c == "V") seen_flags[F_V] = 1'b1;
    if (c == "I") seen_flags[F_I] = 1'b1;
    if (c == "E") seen_flags[F_E] = 1'b1;
    if (last_char == "!" && c == "O") seen_flags[F_XO] = 1'b1;
    if (last_char == "?" && c == "T") seen_flags[F_QT] = 1'b1;
    if (last_char == "!" && c == "T") seen_flags[F_XT] = 1'b1;
    if (last_char == "!" && c == "X") seen_flags[F_XX] = 1'b1;
    if (last_char == "?" && c == "X") seen_flags[F_QX] = 1'b1;
    if (last_char == "?" && c == "W") seen_flags[F_QW] = 1'b1;
    if (last2_char == "?" && last_char == "F" && c == "B") seen_flags[F_QFB] = 1'b1;
    if (last2_char == "?" && last_char == "F" && c == "F") seen_flags[F_QFF] = 1'b1;
    for (int k = 0; k < 3; k++) begin
      start = 2 + 4 * k;
      if (scan_pos == start) begin
        field_digits_ok[k] = dig;
        field_val[k]       = dig ? value_t'(c - "0") : '0;
      end else if (scan_pos > start && scan_pos < start + 3) begin
        field_digits_ok[k] = field_digits_ok[k] && dig;
        if (dig) field_val[k] = value_t'(int'(field_val[k]) * 10 + int'(c) - int'("0"));
      end
    end
    last2_char = last_char;
    last_char  = c;
    scan_pos   = scan_pos + 1;
  endfunction

  // event run in emission order, with its early exits
  function automatic void frame_events();
    if (seen_flags[F_M] && field_complete(0)) queue_event(EV_MODE, field_val[0]);
    if (seen_flags[F_XO]) begin
      queue_event(EV_STOPPED, '0);
      return;
    end
    if (seen_flags[F_V] && field_complete(0)) queue_event(EV_KVP, field_val[0]);
    if (seen_flags[F_I] && field_complete(0)) queue_event(EV_MA, field_val[0]);
    if (seen_flags[F_QT] && field_complete(0)) queue_event(EV_ELAPSED, field_val[0]);
    if (seen_flags[F_XT] && field_complete(0)) queue_event(EV_SHOOT, field_val[0]);
    if (seen_flags[F_XX]) begin
      queue_event(EV_STARTED, '0);
      return;
    end
    if (seen_flags[F_E]) queue_event(EV_ERROR, '0);
    if (seen_flags[F_QX]) begin
      if (field_complete(0)) queue_event(EV_KVP, field_val[0]);
      if (field_complete(1)) queue_event(EV_MA, field_val[1]);
      if (field_complete(2)) queue_event(EV_SHOOT, field_val[2]);
      return;
    end
    if (seen_flags[F_QW] && field_complete(0)) begin
      if (field_val[0] == '0) queue_event(EV_WARM_DONE, '0);
      else if (field_val[0] == WARM_SHORT_VAL) queue_event(EV_WARM_SHORT, '0);
      else if (field_val[0] == WARM_LONG_VAL) queue_event(EV_WARM_LONG, '0);
    end
    if (seen_flags[F_QFB]) begin
      queue_event(EV_LARGE_SPOT, '0);
      return;
    end
    if (seen_flags[F_QFF]) queue_event(EV_SMALL_SPOT, '0);
  endfunction

  function automatic void predict_char(input char_t c, input bit eof);
    int base;
    reply_event_t none_ev;
    if (scan_pos < MAX_LEN) scan_char(c);
    if (eof) begin
      base = expected_events.size();
      frame_events();
      if (expected_events.size() == base) begin
        none_ev.code    = EV_NONE;
        none_ev.value   = '0;
        none_ev.is_last = 1'b0;
        expected_events.push_back(none_ev);
      end
      expected_events[expected_events.size() - 1].is_last = 1'b1;
      clear_frame_state();
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_char(input char_t c, input bit eof);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_char(c, eof);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i], i == text.len() - 1);
  endtask

  task automatic write_enable(input logic [NUM_EVENTS-1:0] mask);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    enable_mask = mask;
  endtask

  // hold the sender until every expected event has come back
  task automatic wait_for_events();
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic string random_token();
    case ($urandom_range(0, 12))
      0:       return "!O";
      1:       return "?T";
      2:       return "!T";
      3:       return "!X";
      4:       return "?X";
      5:       return "?W";
      6:       return "?FB";
      7:       return "?FF";
      8:       return "M";
      9:       return "V";
      10:      return "I";
      11:      return "E";
      default: return "?F";
    endcase
  endfunction

  function automatic char_t random_filler();
    string alphabet = "MVIE!?OTXWFB0123456789";
    if ($urandom_range(0, 99) < 30) return char_t'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  // mostly well-formed frames: tokens at the head and between fields, digit fields
  task automatic send_random_frame(input int max_len, output int length);
    char_t frame [$];
    string token;
    int    value;
    int    at;
    int    digit;
    if (max_len > MAX_LEN && $urandom_range(0, 7) == 0)
      length = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
    else
      length = $urandom_range(1, (max_len < 16) ? max_len : 16);
    for (int i = 0; i < length; i++) frame.push_back(random_filler());
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        if (k == 0) begin
          case ($urandom_range(0, 5))
            0:       value = 0;
            1:       value = WARM_SHORT_VAL;
            2:       value = WARM_LONG_VAL;
            3:       value = 999;
            default: value = $urandom_range(0, 999);
          endcase
        end else begin
          value = $urandom_range(0, 999);
        end
        at = 2 + 4 * k;
        for (int d = 0; d < 3; d++) begin
          digit = (value / ((d == 0) ? 100 : ((d == 1) ? 10 : 1))) % 10;
          if (at + d < length) frame[at + d] = char_t'(int'("0") + digit);
        end
      end
    end
    for (int slot = 0; slot < 4; slot++) begin
      at = (slot == 0) ? 0 : 1 + 4 * slot;
      if ($urandom_range(0, 99) < ((slot == 0) ? 70 : 40)) begin
        token = random_token();
        for (int j = 0; j < token.len(); j++)
          if (at + j < length) frame[at + j] = token[j];
      end
    end
    for (int i = 0; i < length; i++) send_char(frame[i], i == length - 1);
  endtask

  task automatic send_random_frames(input int char_count, input int max_len);
    int sent;
    int length;
    sent = 0;
    while (sent < char_count) begin
      send_random_frame(max_len, length);
      sent += length;
    end
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    reply_event_t exp_ev;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, got code %0d value %0d last %0b",
                 $time, m_tdata[CODE_W-1:0], m_tdata[CODE_W +: VALUE_W], m_tlast);
        errors++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (m_tdata[CODE_W-1:0] !== exp_ev.code) begin
          $display("%0t: event_code expected %0d got %0d",
                   $time, exp_ev.code, m_tdata[CODE_W-1:0]);
          errors++;
        end
        if (m_tdata[CODE_W +: VALUE_W] !== exp_ev.value) begin
          $display("%0t: event_value expected %0d got %0d",
                   $time, exp_ev.value, m_tdata[CODE_W +: VALUE_W]);
          errors++;
        end
        if (m_tdata[15:CODE_W+VALUE_W] !== '0) begin
          $display("%0t: tdata padding expected 0 got %0h",
                   $time, m_tdata[15:CODE_W+VALUE_W]);
          errors++;
        end
        if (m_tlast !== exp_ev.is_last) begin
          $display("%0t: last_event expected %0b got %0b", $time, exp_ev.is_last, m_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // enable is clear after reset, so every frame collapses to the none event
  task automatic test_reset_enable();
    send_char(8'h00, 1'b1);
    send_text("!X");
    wait_for_events();
  endtask

  task automatic test_directed_events();
    write_enable({NUM_EVENTS{1'b1}});
    send_char(8'hFF, 1'b1);
    send_text("MV999IE!T?T");
    send_text("!X");
    send_text("?W100");
    send_text("!O");
    send_text("?FB");
    send_text("?X0");
    wait_for_events();
  endtask

  // tail past the frame limit carries stop and large spot, both must be dropped
  task automatic test_overlong_frame();
    string text;
    text = "?W101";
    while (text.len() < MAX_LEN) text = {text, "."};
    text = {text, "!O?FB"};
    send_text(text);
    wait_for_events();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 16;
    recv_idle_pct = 51;
    send_random_frames(16, MAX_LEN + 8);
    wait_for_events();
    write_enable(NUM_EVENTS'($urandom));
    send_idle_pct = 51;
    recv_idle_pct = 16;
    send_random_frames(16, MAX_LEN + 8);
    wait_for_events();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_enable(NUM_EVENTS'($urandom));
    send_random_frames(12, MAX_LEN + 8);
    wait_for_events();
  endtask

  // with everything masked, every frame must collapse to the none event
  task automatic test_enable_masked();
    write_enable('0);
    send_random_frames(12, 16);
    wait_for_events();
    write_enable({NUM_EVENTS{1'b1}});
  endtask

  // stall the receiver long enough for the frame queue to fill and block input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    send_random_frames(20, 4);
    wait_for_events();
  endtask

  initial begin
    clear_frame_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_enable();
    test_directed_events();
    test_overlong_frame();
    test_random_traffic();
    test_enable_masked();
    test_backpressure();
    wait_for_events();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
